[rtl/core/qrs_pkg.sv]
// quadratic root solver package: widths, status codes and sideband structs
// used by the front end, the newton step and the top level
package qrs_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int NEWTON_STEPS_DEF = 10;
    localparam int COEF_W           = 32;
    localparam int DEN_W            = 33;
    localparam int D_W              = 65;
    localparam int X_W              = 64;

    typedef enum logic [2:0] {
        ST_ALL     = 3'd0,
        ST_NONE    = 3'd1,
        ST_LINEAR  = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_TWO     = 3'd4,
        ST_COMPLEX = 3'd5,
        ST_DEGREE  = 3'd6,
        ST_DIVZERO = 3'd7
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [COEF_W-1:0]  num1a;
        logic               neg1a;
        logic [DEN_W-1:0]   den;
        logic               an;
        logic               bn;
        logic [COEF_W-1:0]  bm;
        logic               dzero;
        logic               done;
    } t_side;

    typedef struct packed {
        t_status status;
        logic    neg;
    } t_lane;

endpackage

[rtl/core/qrs_front.sv]
// front end: operand split, squares and products, discriminant and seed
// depends on qrs_pkg
module qrs_front #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [3:0]                       i_degree,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_c,
    output logic                             o_valid,
    output logic [qrs_pkg::D_W-1:0]          o_d,
    output logic [qrs_pkg::X_W-1:0]          o_x,
    output qrs_pkg::t_side                   o_side
);

    localparam int CW = qrs_pkg::COEF_W;
    localparam int DW = qrs_pkg::D_W;
    localparam int XW = qrs_pkg::X_W;
    localparam logic [DW-1:0] ONE2 = DW'(1) << (2 * FRAC_BITS);
    localparam logic [XW-1:0] ONE  = XW'(1) << FRAC_BITS;

    logic          r_v1, r_v2, r_v3;
    logic [3:0]    r_deg1, r_deg2;
    logic [CW-1:0] r_am1, r_bm1, r_cm1, r_am2, r_bm2, r_cm2;
    logic          r_an1, r_bn1, r_cn1, r_an2, r_bn2, r_cn2;
    logic [63:0]   r_b2, r_acm;
    logic [DW-1:0] r_d;
    logic [XW-1:0] r_x;
    qrs_pkg::t_side r_side;

    logic [DW-1:0] b2w, m4, dsum, d;
    logic          acn, dpos, dneg;
    qrs_pkg::t_side n_side;

    function automatic logic [qrs_pkg::DEN_W-1:0] DEN_W_EXT(input logic [CW-1:0] v);
        DEN_W_EXT = {1'b0, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deg1 <= i_degree;
            r_an1  <= i_coef_a[CW-1];
            r_bn1  <= i_coef_b[CW-1];
            r_cn1  <= i_coef_c[CW-1];
            r_am1  <= i_coef_a[CW-1] ? (~i_coef_a + 1'b1) : i_coef_a;
            r_bm1  <= i_coef_b[CW-1] ? (~i_coef_b + 1'b1) : i_coef_b;
            r_cm1  <= i_coef_c[CW-1] ? (~i_coef_c + 1'b1) : i_coef_c;
            r_deg2 <= r_deg1;
            r_an2  <= r_an1;
            r_bn2  <= r_bn1;
            r_cn2  <= r_cn1;
            r_am2  <= r_am1;
            r_bm2  <= r_bm1;
            r_cm2  <= r_cm1;
            r_b2   <= r_bm1 * r_bm1;
            r_acm  <= r_am1 * r_cm1;
            r_d    <= d;
            r_side <= n_side;
            if (d < ONE2) begin
                r_x <= ONE;
            end else begin
                r_x <= XW'(d >> (FRAC_BITS + 1));
            end
        end
    end

    always_comb begin
        b2w  = DW'(r_b2);
        m4   = DW'({r_acm, 2'b00});
        dsum = b2w + m4;
        acn  = (r_an2 != r_cn2) && (r_acm != 64'd0);
        dpos = 1'b0;
        dneg = 1'b0;
        d    = '0;
        if (acn || r_acm == 64'd0) begin
            d    = dsum;
            dpos = dsum != '0;
        end else if (b2w > m4) begin
            d    = b2w - m4;
            dpos = 1'b1;
        end else if (b2w < m4) begin
            d    = m4 - b2w;
            dneg = 1'b1;
        end

        n_side.an    = r_an2;
        n_side.bn    = r_bn2;
        n_side.bm    = r_bm2;
        n_side.dzero = d == '0;
        n_side.done  = d == ONE2;
        if (r_deg2 == 4'd1) begin
            n_side.num1a = r_cm2;
            n_side.neg1a = (r_cm2 != '0) && (r_cn2 == r_bn2);
            n_side.den   = DEN_W_EXT(r_bm2);
        end else begin
            n_side.num1a = r_bm2;
            n_side.neg1a = (r_bm2 != '0) && (r_bn2 == r_an2);
            n_side.den   = {r_am2, 1'b0};
        end
        if (r_deg2 > 4'd2) begin
            n_side.status = qrs_pkg::ST_DEGREE;
        end else if (r_deg2 == 4'd0) begin
            n_side.status = (r_cm2 == '0) ? qrs_pkg::ST_ALL : qrs_pkg::ST_NONE;
        end else if (r_deg2 == 4'd1) begin
            n_side.status = (r_bm2 == '0) ? qrs_pkg::ST_DIVZERO : qrs_pkg::ST_LINEAR;
        end else if (r_am2 == '0) begin
            n_side.status = qrs_pkg::ST_DIVZERO;
        end else if (dpos) begin
            n_side.status = qrs_pkg::ST_TWO;
        end else if (dneg) begin
            n_side.status = qrs_pkg::ST_COMPLEX;
        end else begin
            n_side.status = qrs_pkg::ST_DOUBLE;
        end
    end

    assign o_valid = r_v3;
    assign o_d     = r_d;
    assign o_x     = r_x;
    assign o_side  = r_side;

endmodule

[rtl/core/qrs_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing outside this file
module qrs_div #(
    parameter int NW = 65,
    parameter int DW = 64,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_v   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_d   [NW];
    logic [SW-1:0] r_s   [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem, p_d;
        logic [NW-1:0] p_nq;
        logic [SW-1:0] p_s;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = '0;
            assign p_nq  = i_num;
            assign p_d   = i_den;
            assign p_s   = i_side;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_nq  = r_nq[k-1];
            assign p_d   = r_d[k-1];
            assign p_s   = r_s[k-1];
        end

        assign trial = {p_rem, p_nq[NW-1]};
        assign ge    = trial >= {1'b0, p_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(trial - {1'b0, p_d}) : trial[DW-1:0];
                r_nq[k]  <= {p_nq[NW-2:0], ge};
                r_d[k]   <= p_d;
                r_s[k]   <= p_s;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_side  = r_s[NW-1];

endmodule

[rtl/core/qrs_nstep.sv]
// one newton step x = (x + d/x)/2 for the square root, clamped
// depends on qrs_pkg and qrs_div
module qrs_nstep (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [qrs_pkg::D_W-1:0] i_d,
    input  logic [qrs_pkg::X_W-1:0] i_x,
    input  qrs_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [qrs_pkg::D_W-1:0] o_d,
    output logic [qrs_pkg::X_W-1:0] o_x,
    output qrs_pkg::t_side          o_side
);

    localparam int DW = qrs_pkg::D_W;
    localparam int XW = qrs_pkg::X_W;
    localparam int SW = $bits(qrs_pkg::t_side);
    localparam int BW = DW + XW + SW;
    localparam logic [XW-1:0] LIM  = XW'(1) << 62;
    localparam logic [DW-1:0] LIMQ = DW'(1) << 62;

    logic [XW-1:0] xa, xc, qx, qv;
    logic [DW-1:0] quo;
    logic [BW-1:0] bundle_in, bundle_out;
    logic          dv;
    logic [XW:0]   sum;

    logic          r_v;
    logic [DW-1:0] r_d;
    logic [XW-1:0] r_x;
    qrs_pkg::t_side r_side;

    assign xa        = (i_x == '0) ? XW'(1) : i_x;
    assign xc        = (xa > LIM) ? LIM : xa;
    assign bundle_in = {i_d, xc, i_side};

    qrs_div #(
        .NW (DW),
        .DW (XW),
        .SW (BW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (i_d),
        .i_den   (xa),
        .i_side  (bundle_in),
        .o_valid (dv),
        .o_quo   (quo),
        .o_side  (bundle_out)
    );

    assign qx  = bundle_out[SW +: XW];
    assign qv  = (quo > LIMQ) ? LIM : quo[XW-1:0];
    assign sum = {1'b0, qx} + {1'b0, qv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= bundle_out[SW+XW +: DW];
            r_x    <= sum[XW:1];
            r_side <= bundle_out[SW-1:0];
        end
    end

    assign o_valid = r_v;
    assign o_d     = r_d;
    assign o_x     = r_x;
    assign o_side  = r_side;

endmodule

[rtl/core/quadratic_root_solver.sv]
// top level of the quadratic root solver: front end, newton chain,
// root division lanes and output register; depends on qrs_pkg and submodules
//
// usage
//   input channel: i_valid / o_stall carry one word per equation: degree and
//   signed Q16.16 coefficients a, b, c. output channel: o_valid / i_stall
//   carry the status code, two roots and the overflow flag.
//   a word is taken at a clock edge with valid high and stall low.
// throughput
//   one word per cycle, sustained while o_stall is low; every stage is a register stage.
// depth
//   the depth of the pipe is set by the per-bit restoring dividers of
//   the newton chain and of the root lanes
// stall
//   an output word held by i_stall moves into a skid register; while it is
//   full the whole pipe freezes and o_stall is high; nothing is lost.
// reset
//   i_rst_n low clears all valid bits; the pipe comes up empty.
module quadratic_root_solver #(
    parameter int FRAC_BITS    = qrs_pkg::FRAC_BITS_DEF,
    parameter int NEWTON_STEPS = qrs_pkg::NEWTON_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [3:0]                        i_degree,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] i_coef_c,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic signed [qrs_pkg::COEF_W-1:0] o_root_one,
    output logic signed [qrs_pkg::COEF_W-1:0] o_root_two,
    output logic                              o_overflow
);

    localparam int DW  = qrs_pkg::D_W;
    localparam int XW  = qrs_pkg::X_W;
    localparam int CW  = qrs_pkg::COEF_W;
    localparam int NWF = XW + FRAC_BITS;
    localparam int LW  = $bits(qrs_pkg::t_lane);
    localparam logic [XW-1:0]  ONE    = XW'(1) << FRAC_BITS;
    localparam logic [NWF-1:0] LIMNEG = NWF'(33'h080000000);
    localparam logic [NWF-1:0] LIMPOS = NWF'(33'h07fffffff);

    logic en;

    logic           r_sk_v;
    logic [2:0]     r_sk_status;
    logic [CW-1:0]  r_sk_r1, r_sk_r2;
    logic           r_sk_ovf;

    logic           w_v    [NEWTON_STEPS+1];
    logic [DW-1:0]  w_d    [NEWTON_STEPS+1];
    logic [XW-1:0]  w_x    [NEWTON_STEPS+1];
    qrs_pkg::t_side w_side [NEWTON_STEPS+1];

    assign en      = !r_sk_v;
    assign o_stall = r_sk_v;

    qrs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_degree (i_degree),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_valid  (w_v[0]),
        .o_d      (w_d[0]),
        .o_x      (w_x[0]),
        .o_side   (w_side[0])
    );

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
        qrs_nstep u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[k]),
            .i_d     (w_d[k]),
            .i_x     (w_x[k]),
            .i_side  (w_side[k]),
            .o_valid (w_v[k+1]),
            .o_d     (w_d[k+1]),
            .o_x     (w_x[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // root lane preparation
    qrs_pkg::t_side sd;
    logic [XW-1:0]   s, m1, m2;
    logic [XW+1:0]   nb, t1, t2;
    logic [NWF-1:0]  n_num1, n_num2;
    qrs_pkg::t_lane  n_lane1;
    logic            n_neg2;

    logic            r_pv;
    logic [NWF-1:0]  r_num1, r_num2;
    logic [qrs_pkg::DEN_W-1:0] r_den;
    qrs_pkg::t_lane  r_lane1;
    logic            r_neg2;

    always_comb begin
        sd = w_side[NEWTON_STEPS];
        if (sd.dzero) begin
            s = '0;
        end else if (sd.done) begin
            s = ONE;
        end else begin
            s = w_x[NEWTON_STEPS];
        end
        nb = sd.bn ? {{(XW+2-CW){1'b0}}, sd.bm} : (~{{(XW+2-CW){1'b0}}, sd.bm} + 1'b1);
        t1 = nb + {2'b00, s};
        t2 = nb - {2'b00, s};
        m1 = t1[XW+1] ? XW'(~t1 + 1'b1) : t1[XW-1:0];
        m2 = t2[XW+1] ? XW'(~t2 + 1'b1) : t2[XW-1:0];
        n_lane1.status = sd.status;
        n_lane1.neg    = sd.neg1a;
        n_num1 = {{(XW-CW){1'b0}}, sd.num1a, {FRAC_BITS{1'b0}}};
        n_num2 = {s, {FRAC_BITS{1'b0}}};
        n_neg2 = (s != '0) && sd.an;
        if (sd.status == qrs_pkg::ST_TWO) begin
            n_num1      = {m1, {FRAC_BITS{1'b0}}};
            n_lane1.neg = (m1 != '0) && (t1[XW+1] != sd.an);
            n_num2      = {m2, {FRAC_BITS{1'b0}}};
            n_neg2      = (m2 != '0) && (t2[XW+1] != sd.an);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= w_v[NEWTON_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num1  <= n_num1;
            r_num2  <= n_num2;
            r_den   <= sd.den;
            r_lane1 <= n_lane1;
            r_neg2  <= n_neg2;
        end
    end

    logic           q_v;
    logic [NWF-1:0] q1, q2;
    logic [LW-1:0]  q_side1;
    logic           q_neg2;

    qrs_div #(
        .NW (NWF),
        .DW (qrs_pkg::DEN_W),
        .SW (LW)
    ) u_lane1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_num   (r_num1),
        .i_den   (r_den),
        .i_side  (r_lane1),
        .o_valid (q_v),
        .o_quo   (q1),
        .o_side  (q_side1)
    );

    qrs_div #(
        .NW (NWF),
        .DW (qrs_pkg::DEN_W),
        .SW (1)
    ) u_lane2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_num   (r_num2),
        .i_den   (r_den),
        .i_side  (r_neg2),
        .o_valid (),
        .o_quo   (q2),
        .o_side  (q_neg2)
    );

    // saturation and output word
    qrs_pkg::t_lane ql;
    logic [NWF-1:0] lim1, lim2, mag1, mag2;
    logic           sat1, sat2, use1, use2;
    logic [CW-1:0]  v1, v2;

    always_comb begin
        ql   = q_side1;
        lim1 = ql.neg ? LIMNEG : LIMPOS;
        lim2 = q_neg2 ? LIMNEG : LIMPOS;
        sat1 = q1 > lim1;
        sat2 = q2 > lim2;
        mag1 = sat1 ? lim1 : q1;
        mag2 = sat2 ? lim2 : q2;
        v1   = ql.neg ? (~mag1[CW-1:0] + 1'b1) : mag1[CW-1:0];
        v2   = q_neg2 ? (~mag2[CW-1:0] + 1'b1) : mag2[CW-1:0];
        use1 = (ql.status == qrs_pkg::ST_LINEAR) || (ql.status == qrs_pkg::ST_DOUBLE)
            || (ql.status == qrs_pkg::ST_TWO) || (ql.status == qrs_pkg::ST_COMPLEX);
        use2 = (ql.status == qrs_pkg::ST_TWO) || (ql.status == qrs_pkg::ST_COMPLEX);
    end

    logic           r_ov;
    logic [2:0]     r_status;
    logic [CW-1:0]  r_r1, r_r2;
    logic           r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= ql.status;
            r_r1     <= use1 ? v1 : '0;
            r_r2     <= use2 ? v2 : '0;
            r_ovf    <= (use1 && sat1) || (use2 && sat2);
        end
    end

    // skid register for a word held by the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (!i_stall) begin
                r_sk_v <= 1'b0;
            end
        end else begin
            r_sk_v <= r_ov && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_sk_status <= r_status;
            r_sk_r1     <= r_r1;
            r_sk_r2     <= r_r2;
            r_sk_ovf    <= r_ovf;
        end
    end

    assign o_valid    = r_sk_v || r_ov;
    assign o_status   = r_sk_v ? r_sk_status : r_status;
    assign o_root_one = r_sk_v ? r_sk_r1 : r_r1;
    assign o_root_two = r_sk_v ? r_sk_r2 : r_r2;
    assign o_overflow = r_sk_v ? r_sk_ovf : r_ovf;

`ifndef SYNTHESIS
    a_ovf_needs_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> (o_status == qrs_pkg::ST_LINEAR)
            || (o_status == qrs_pkg::ST_DOUBLE) || (o_status == qrs_pkg::ST_TWO)
            || (o_status == qrs_pkg::ST_COMPLEX))
        else $error("overflow without a root");
    a_no_roots : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == qrs_pkg::ST_ALL) || (o_status == qrs_pkg::ST_NONE)
            || (o_status == qrs_pkg::ST_DEGREE) || (o_status == qrs_pkg::ST_DIVZERO))
        |-> (o_root_one == '0) && (o_root_two == '0))
        else $error("root set for a rootless status");
    a_single_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == qrs_pkg::ST_LINEAR) || (o_status == qrs_pkg::ST_DOUBLE))
        |-> o_root_two == '0)
        else $error("second root set for a single root status");
    a_stall_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_pv) && $stable(q_v))
        else $error("pipe moved during stall");
`endif

endmodule
